[hw/rtl/dps_pkg.sv]
// shared types and one function for the deadline priority scheduler
`default_nettype none

package dps_pkg;

  localparam logic [7:0] QUANTUM_RESET = 8'd3;
  localparam int PRIO_MAX = 19;
  localparam int PRIO_MIN = -20;

  typedef struct packed {
    logic [7:0]         id;
    logic [15:0]        remaining;
    logic [15:0]        deadline;
    logic signed [5:0]  prio;
    logic [31:0]        first_start;
    logic               started;
  } entry_t;

  typedef enum logic [2:0] {
    WD_NEW,
    WD_MOVE,
    WD_HEAD,
    WD_REPRIO,
    WD_CUR
  } wsrc_t;

  typedef enum logic [1:0] {
    RK_ACCEPT,
    RK_REJECT,
    RK_IDLE,
    RK_RUN
  } rkind_t;

  typedef struct packed {
    logic   capture;
    logic   rd_en;
    logic   wr_en;
    wsrc_t  wsrc;
    logic   load_cur;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   report;
    rkind_t kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic gt_new;
    logic gt_cur;
    logic head_done;
  } status_t;

  function automatic logic signed [5:0] urgency(input logic [15:0] dl,
                                                input logic [31:0] now);
    logic signed [33:0] diff;
    begin
      diff = $signed({18'd0, dl}) - $signed({2'd0, now});
      if (diff > 34'sd19) begin
        urgency = 6'sd19;
      end else if (diff < -34'sd20) begin
        urgency = -6'sd20;
      end else begin
        urgency = diff[5:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dps_datapath.sv]
// scheduler datapath: task memory, time and dispatch counters, result registers
`default_nettype none

module dps_datapath #(
  parameter int MAX_TASKS = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  dps_pkg::cmd_t         cmd,
  input  wire  [AW-1:0]         rd_addr,
  input  wire  [AW-1:0]         wr_addr,
  input  wire  [7:0]            task_id,
  input  wire  [15:0]           task_deadline,
  input  wire  [15:0]           task_burst,
  input  wire                   cfg_we,
  input  wire  [7:0]            cfg_data,
  output logic [CW-1:0]         count,
  output dps_pkg::status_t      st,
  output logic                  done,
  output logic                  accepted,
  output logic                  idle,
  output logic [7:0]            run_id,
  output logic [7:0]            slice_len,
  output logic                  finished,
  output logic [31:0]           finish_time,
  output logic [31:0]           turnaround,
  output logic signed [5:0]     run_priority,
  output logic [31:0]           dispatch_total
);
  import dps_pkg::*;

  entry_t mem [MAX_TASKS];
  entry_t rdata;
  entry_t cur;
  entry_t wdata;

  logic [7:0]        quantum;
  logic [31:0]       now;
  logic [31:0]       dcount;
  logic [7:0]        req_id;
  logic [15:0]       req_dl;
  logic [15:0]       req_burst;
  logic signed [5:0] req_prio;

  logic [7:0]  q_eff;
  logic [7:0]  slice;
  logic [15:0] rem_next;
  logic [31:0] fs;
  logic [31:0] now_next;

  always_comb begin
    q_eff = (quantum == 8'd0) ? 8'd1 : quantum;
    slice = (rdata.remaining < {8'd0, q_eff}) ? rdata.remaining[7:0] : q_eff;
    rem_next = rdata.remaining - {8'd0, slice};
    fs = rdata.started ? rdata.first_start : now;
    now_next = now + {24'd0, slice};
  end

  always_comb begin
    st.full = (count == CW'(MAX_TASKS));
    st.empty = (count == '0);
    st.gt_new = (rdata.prio > req_prio);
    st.gt_cur = (cur.prio > rdata.prio);
    st.head_done = (rem_next == 16'd0);
  end

  always_comb begin
    wdata = rdata;
    case (cmd.wsrc)
      WD_NEW: begin
        wdata.id = req_id;
        wdata.remaining = req_burst;
        wdata.deadline = req_dl;
        wdata.prio = req_prio;
        wdata.first_start = 32'd0;
        wdata.started = 1'b0;
      end
      WD_MOVE: wdata = rdata;
      WD_HEAD: begin
        wdata.remaining = rem_next;
        wdata.first_start = fs;
        wdata.started = 1'b1;
      end
      WD_REPRIO: wdata.prio = urgency(rdata.deadline, now);
      WD_CUR: wdata = cur;
      default: wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.load_cur) begin
      cur <= rdata;
    end
    if (cmd.capture) begin
      req_id <= task_id;
      req_dl <= task_deadline;
      req_burst <= task_burst;
      req_prio <= urgency(task_deadline, now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
      now <= '0;
      dcount <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_data;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      done <= cmd.report;
      if (cmd.report) begin
        case (cmd.kind)
          RK_IDLE: now <= now + 32'd1;
          RK_RUN: begin
            now <= now_next;
            dcount <= dcount + 32'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      accepted <= (cmd.kind == RK_ACCEPT);
      idle <= (cmd.kind == RK_IDLE);
      run_id <= '0;
      slice_len <= '0;
      finished <= 1'b0;
      finish_time <= '0;
      turnaround <= '0;
      run_priority <= '0;
      dispatch_total <= dcount;
      if (cmd.kind == RK_RUN) begin
        run_id <= rdata.id;
        slice_len <= slice;
        finished <= st.head_done;
        finish_time <= now_next;
        turnaround <= st.head_done ? (now_next - fs) : 32'd0;
        run_priority <= rdata.prio;
        dispatch_total <= dcount + 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dps_ctrl.sv]
// scheduler controller: sequences insert, remove, reprioritize and sort passes
`default_nettype none

module dps_ctrl #(
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire                   mode,
  input  wire  [CW-1:0]         count,
  input  dps_pkg::status_t      st,
  output logic                  busy,
  output dps_pkg::cmd_t         cmd,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr
);
  import dps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ARR, S_ARD, S_ACMP, S_AWR,
    S_DSP, S_HEAD, S_SRD, S_SWR, S_PRD, S_PWR,
    S_IRD, S_ILD, S_JRD, S_JCMP, S_IWR
  } state_t;

  state_t state;
  logic [CW-1:0] k;
  logic [CW-1:0] j;

  always_comb begin
    cmd = '0;
    cmd.wsrc = WD_MOVE;
    cmd.kind = RK_ACCEPT;
    rd_addr = k[AW-1:0];
    wr_addr = k[AW-1:0];
    case (state)
      S_IDLE: cmd.capture = start && !busy;
      S_ARR: begin
        if (st.full) begin
          cmd.report = 1'b1;
          cmd.kind = RK_REJECT;
        end
      end
      S_ARD: begin
        cmd.rd_en = 1'b1;
        rd_addr = AW'(k - CW'(1));
      end
      S_ACMP: begin
        cmd.wr_en = st.gt_new;
      end
      S_AWR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc = WD_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.report = 1'b1;
        cmd.kind = RK_ACCEPT;
      end
      S_DSP: begin
        if (st.empty) begin
          cmd.report = 1'b1;
          cmd.kind = RK_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr = '0;
        end
      end
      S_HEAD: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc = WD_HEAD;
        wr_addr = '0;
        cmd.report = 1'b1;
        cmd.kind = RK_RUN;
        cmd.cnt_dec = st.head_done;
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        rd_addr = AW'(k + CW'(1));
      end
      S_SWR: cmd.wr_en = 1'b1;
      S_PRD: cmd.rd_en = 1'b1;
      S_PWR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc = WD_REPRIO;
      end
      S_IRD: cmd.rd_en = 1'b1;
      S_ILD: cmd.load_cur = 1'b1;
      S_JRD: begin
        cmd.rd_en = 1'b1;
        rd_addr = j[AW-1:0];
      end
      S_JCMP: begin
        cmd.wr_en = st.gt_cur;
        cmd.wsrc = WD_CUR;
        cmd.load_cur = st.gt_cur;
        wr_addr = j[AW-1:0];
      end
      S_IWR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc = WD_CUR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      k <= '0;
      j <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            busy <= 1'b1;
            state <= mode ? S_DSP : S_ARR;
          end
        end
        S_ARR: begin
          if (st.full) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            k <= count;
            state <= (count <= CW'(1)) ? S_AWR : S_ARD;
          end
        end
        S_ARD: state <= S_ACMP;
        S_ACMP: begin
          if (st.gt_new) begin
            k <= k - CW'(1);
            state <= (k == CW'(2)) ? S_AWR : S_ARD;
          end else begin
            state <= S_AWR;
          end
        end
        S_AWR: begin
          busy <= 1'b0;
          state <= S_IDLE;
        end
        S_DSP: begin
          if (st.empty) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          k <= '0;
          if (st.head_done) begin
            if (count == CW'(1)) begin
              busy <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_SRD;
            end
          end else begin
            state <= S_PRD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (k + CW'(1) == count) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            k <= k + CW'(1);
            state <= S_SRD;
          end
        end
        S_PRD: state <= S_PWR;
        S_PWR: begin
          if (k + CW'(1) == count) begin
            k <= '0;
            if (count == CW'(1)) begin
              busy <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_IRD;
            end
          end else begin
            k <= k + CW'(1);
            state <= S_PRD;
          end
        end
        S_IRD: state <= S_ILD;
        S_ILD: begin
          j <= k + CW'(1);
          state <= S_JRD;
        end
        S_JRD: state <= S_JCMP;
        S_JCMP: begin
          if (j + CW'(1) == count) begin
            state <= S_IWR;
          end else begin
            j <= j + CW'(1);
            state <= S_JRD;
          end
        end
        S_IWR: begin
          if (k + CW'(2) == count) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            k <= k + CW'(1);
            state <= S_IRD;
          end
        end
        default: begin
          busy <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/deadline_priority_scheduler.sv]
// top level of the deadline priority scheduler
//
// A request is taken when start is high and busy is low. mode 0 is a task
// arrival (task_id, task_deadline, task_burst), mode 1 dispatches one slice.
// Every request gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, results are simply presented.
// The quantum register is written with cfg_we/cfg_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
// After a dispatch result busy stays high while the task memory is reworked:
// a finished task is removed, an unfinished one gets a priority refresh and,
// if other tasks remain, an exchange sort, all through the single port pair
// of the task memory. Reset empties the queue, clears time and dispatch
// counters and sets the quantum to 3.
`default_nettype none

module deadline_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire               mode,
  input  wire  [7:0]        task_id,
  input  wire  [15:0]       task_deadline,
  input  wire  [15:0]       task_burst,
  input  wire               cfg_we,
  input  wire  [7:0]        cfg_data,
  output logic              done,
  output logic              accepted,
  output logic              idle,
  output logic [7:0]        run_id,
  output logic [7:0]        slice_len,
  output logic              finished,
  output logic [31:0]       finish_time,
  output logic [31:0]       turnaround,
  output logic signed [5:0] run_priority,
  output logic [31:0]       dispatch_total
);
  import dps_pkg::*;

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  cmd_t          cmd;
  status_t       st;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  dps_ctrl #(
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .mode(mode),
    .count(count),
    .st(st),
    .busy(busy),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr)
  );

  dps_datapath #(
    .MAX_TASKS(MAX_TASKS),
    .AW(AW),
    .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .task_id(task_id),
    .task_deadline(task_deadline),
    .task_burst(task_burst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .count(count),
    .st(st),
    .done(done),
    .accepted(accepted),
    .idle(idle),
    .run_id(run_id),
    .slice_len(slice_len),
    .finished(finished),
    .finish_time(finish_time),
    .turnaround(turnaround),
    .run_priority(run_priority),
    .dispatch_total(dispatch_total)
  );

endmodule

`default_nettype wire
